// ===== design/tdec_pkg.sv =====
// Shared codes, field widths and helpers for the truss decomposition block.
`timescale 1ns / 1ps

package tdec_pkg;

    localparam int MODE_W   = 2;
    localparam int VERT_W   = 6;
    localparam int INDEX_W  = 9;
    localparam int STATUS_W = 2;
    localparam int CLASS_W  = 6;
    localparam int BOUND_W  = 7;
    localparam int COUNT_W  = 10;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam mode_t MODE_CLEAR   = 2'd0;
    localparam mode_t MODE_LOAD    = 2'd1;
    localparam mode_t MODE_COMPUTE = 2'd2;
    localparam mode_t MODE_QUERY   = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_BAD   = 2'd2;
    localparam status_t ST_NOCLS = 2'd3;

    // class below bound - 2, compared without underflow: a bound under 2 removes nothing
    function automatic logic is_removable(input logic [7:0] cls,
                                          input logic [BOUND_W-1:0] bound);
        return (10'(cls) + 10'd2) < 10'(bound);
    endfunction

endpackage

// ===== design/tdec_if.sv =====
// Request and response channel interfaces.
`timescale 1ns / 1ps

interface tdec_req_if
    import tdec_pkg::*;
();
    logic                 valid;
    logic                 ready;
    mode_t                mode;
    logic [VERT_W-1:0]    vertex_a;
    logic [VERT_W-1:0]    vertex_b;
    logic [INDEX_W-1:0]   edge_index;

    modport source (output valid, mode, vertex_a, vertex_b, edge_index, input ready);
    modport sink   (input valid, mode, vertex_a, vertex_b, edge_index, output ready);
endinterface

interface tdec_rsp_if
    import tdec_pkg::*;
();
    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [CLASS_W-1:0]   edge_class;
    logic                 removable;
    logic [BOUND_W-1:0]   clique_upper_bound;
    logic [COUNT_W-1:0]   removable_count;
    logic [COUNT_W-1:0]   loaded_count;

    modport source (output valid, status, edge_class, removable, clique_upper_bound,
                    removable_count, loaded_count, input ready);
    modport sink   (input valid, status, edge_class, removable, clique_upper_bound,
                    removable_count, loaded_count, output ready);
endinterface

// ===== design/tdec_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tdec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/truss_decomposition.sv =====
// Truss decomposition engine: top level with sequencer and state memories.
//
//  channel | dir | handshake        | payload
//  req     | in  | valid / ready    | mode, vertex_a, vertex_b, edge_index
//  rsp     | out | valid / ready    | status, edge_class, removable, bounds, counts
//  cfg     | in  | cfg_we           | cfg_wdata (clique bound)
//
// One request at a time. Every request ends in a final count scan of the class memory
// over the L loaded edges when classes are valid (L = loaded edges). Compute: a copy
// pass, a support count per edge, then per peeled edge a minimum scan and a neighbour
// walk with extra steps per triangle; the single read port of each memory sets these.
// Reset clears control state and row valid bits at once; no clearing pass.
// A finished response waits in the output register while the next request is taken.
`timescale 1ns / 1ps

module truss_decomposition
    import tdec_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    tdec_req_if.sink          req,
    tdec_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic [BOUND_W-1:0] cfg_wdata
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int SW = VW;
    localparam int EW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int MW = (VW + 1 > CW) ? VW + 1 : CW;
    localparam int XW = (MW > INDEX_W) ? MW : INDEX_W;
    localparam int PD = 1 << (2 * VW);
    localparam logic [MAX_VERTICES-1:0] ONE_ROW = MAX_VERTICES'(1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_LCHK   = 5'd1;
    localparam logic [4:0] S_LWB    = 5'd2;
    localparam logic [4:0] S_COPY   = 5'd3;
    localparam logic [4:0] S_SROWU  = 5'd4;
    localparam logic [4:0] S_SROWV  = 5'd5;
    localparam logic [4:0] S_SLATV  = 5'd6;
    localparam logic [4:0] S_SCNT   = 5'd7;
    localparam logic [4:0] S_PSCAN  = 5'd8;
    localparam logic [4:0] S_PSEL   = 5'd9;
    localparam logic [4:0] S_PENDS  = 5'd10;
    localparam logic [4:0] S_PRU    = 5'd11;
    localparam logic [4:0] S_PRV    = 5'd12;
    localparam logic [4:0] S_PW     = 5'd13;
    localparam logic [4:0] S_PPA    = 5'd14;
    localparam logic [4:0] S_PSA    = 5'd15;
    localparam logic [4:0] S_PPB    = 5'd16;
    localparam logic [4:0] S_PSB    = 5'd17;
    localparam logic [4:0] S_PCLR   = 5'd18;
    localparam logic [4:0] S_PCLR2  = 5'd19;
    localparam logic [4:0] S_FSCAN  = 5'd20;
    localparam logic [4:0] S_DONE   = 5'd21;

    logic [4:0]              state_reg;
    mode_t                   mode_reg;
    logic [VERT_W-1:0]       va_reg, vb_reg;
    logic [INDEX_W-1:0]      q_reg;
    status_t                 status_reg;
    logic [MW-1:0]           cnt_reg;
    logic [CW-1:0]           done_reg;
    logic [VW-1:0]           u_reg, v_reg;
    logic [MAX_VERTICES-1:0] row_u_reg, row_v_reg;
    logic [SW-1:0]           sacc_reg;
    logic [SW:0]             best_s_reg;
    logic [EW-1:0]           best_reg;
    logic                    found_reg;
    logic [SW-1:0]           k_reg;
    logic [EW-1:0]           e_reg;
    logic [CW-1:0]           loaded_reg;
    logic                    cv_reg;
    logic [SW-1:0]           maxc_reg;
    logic [MAX_VERTICES-1:0] rowvalid_reg;
    logic [BOUND_W-1:0]      bound_reg;
    logic [CW-1:0]           rcnt_reg;
    logic [SW-1:0]           qcls_reg;

    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic [CLASS_W-1:0]      out_class_reg;
    logic                    out_rem_reg;
    logic [BOUND_W-1:0]      out_cub_reg;
    logic [COUNT_W-1:0]      out_rcnt_reg;
    logic [COUNT_W-1:0]      out_ecnt_reg;

    // memory ports
    logic                    adj_we, wrk_we, pair_we, ends_we, sup_we, cls_we;
    logic [VW-1:0]           adj_waddr, adj_raddr, wrk_waddr, wrk_raddr;
    logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata, wrk_wdata, wrk_rdata;
    logic [2*VW-1:0]         pair_waddr, pair_raddr;
    logic [EW-1:0]           pair_wdata, pair_rdata;
    logic [EW-1:0]           ends_waddr, ends_raddr, sup_waddr, sup_raddr;
    logic [EW-1:0]           cls_waddr, cls_raddr;
    logic [2*VW-1:0]         ends_wdata, ends_rdata;
    logic [SW:0]             sup_wdata, sup_rdata;
    logic [SW-1:0]           cls_wdata, cls_rdata;

    tdec_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
        .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
        .raddr(adj_raddr), .rdata(adj_rdata));
    tdec_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_wrk (
        .clk(clk), .we(wrk_we), .waddr(wrk_waddr), .wdata(wrk_wdata),
        .raddr(wrk_raddr), .rdata(wrk_rdata));
    tdec_ram #(.WIDTH(EW), .DEPTH(PD)) u_pair (
        .clk(clk), .we(pair_we), .waddr(pair_waddr), .wdata(pair_wdata),
        .raddr(pair_raddr), .rdata(pair_rdata));
    tdec_ram #(.WIDTH(2 * VW), .DEPTH(MAX_EDGES)) u_ends (
        .clk(clk), .we(ends_we), .waddr(ends_waddr), .wdata(ends_wdata),
        .raddr(ends_raddr), .rdata(ends_rdata));
    tdec_ram #(.WIDTH(SW + 1), .DEPTH(MAX_EDGES)) u_sup (
        .clk(clk), .we(sup_we), .waddr(sup_waddr), .wdata(sup_wdata),
        .raddr(sup_raddr), .rdata(sup_rdata));
    tdec_ram #(.WIDTH(SW), .DEPTH(MAX_EDGES)) u_cls (
        .clk(clk), .we(cls_we), .waddr(cls_waddr), .wdata(cls_wdata),
        .raddr(cls_raddr), .rdata(cls_rdata));

    // unordered vertex pair -> pair memory address
    function automatic logic [2*VW-1:0] pair_key(input logic [VW-1:0] x,
                                                 input logic [VW-1:0] y);
        return (x < y) ? {x, y} : {y, x};
    endfunction

    function automatic logic [SW:0] sup_dec(input logic [SW:0] d);
        return {d[SW], (d[SW-1:0] == '0) ? d[SW-1:0] : d[SW-1:0] - 1'b1};
    endfunction

    logic                    accept;
    logic                    bad_load;
    logic [VW-1:0]           a_idx, b_idx;
    logic [MW-1:0]           prev;
    logic                    w_end, scan_end, common_bit;
    logic [MAX_VERTICES-1:0] adj_row;
    logic [SW-1:0]           k_next;
    logic                    last_edge;
    logic [7:0]              cls_w;
    logic [8:0]              ub_w;
    logic                    out_load;

    assign accept     = req.valid && req.ready;
    assign req.ready  = (state_reg == S_IDLE);
    assign a_idx      = VW'(va_reg);
    assign b_idx      = VW'(vb_reg);
    assign bad_load   = (req.vertex_a == req.vertex_b)
                     || (9'(req.vertex_a) >= 9'(MAX_VERTICES))
                     || (9'(req.vertex_b) >= 9'(MAX_VERTICES));
    assign prev       = cnt_reg - 1'b1;
    assign w_end      = (cnt_reg == MW'(MAX_VERTICES));
    assign scan_end   = (cnt_reg == MW'(loaded_reg));
    assign common_bit = row_u_reg[cnt_reg[VW-1:0]] && row_v_reg[cnt_reg[VW-1:0]];
    assign k_next     = (best_s_reg[SW-1:0] > k_reg) ? best_s_reg[SW-1:0] : k_reg;
    assign last_edge  = (CW'(done_reg + 1'b1) == loaded_reg);
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // row read back from the adjacency memory; a row never written is empty
    always_comb
    begin
        adj_row = '0;
        if (state_reg == S_LCHK)
        begin
            adj_row = rowvalid_reg[a_idx] ? adj_rdata : '0;
        end
        else if (state_reg == S_LWB)
        begin
            adj_row = rowvalid_reg[b_idx] ? adj_rdata : '0;
        end
        else
        begin
            adj_row = rowvalid_reg[prev[VW-1:0]] ? adj_rdata : '0;
        end
    end

    always_comb
    begin
        adj_we = 1'b0;  adj_waddr = a_idx;  adj_wdata = adj_row | (ONE_ROW << b_idx);
        adj_raddr = VW'(req.vertex_a);
        wrk_we = 1'b0;  wrk_waddr = prev[VW-1:0];  wrk_wdata = adj_row;
        wrk_raddr = ends_rdata[2*VW-1:VW];
        pair_we = 1'b0; pair_waddr = pair_key(a_idx, b_idx);
        pair_wdata = loaded_reg[EW-1:0];
        pair_raddr = pair_key(u_reg, cnt_reg[VW-1:0]);
        ends_we = 1'b0; ends_waddr = loaded_reg[EW-1:0]; ends_wdata = {a_idx, b_idx};
        ends_raddr = '0;
        sup_we = 1'b0;  sup_waddr = done_reg[EW-1:0]; sup_wdata = {1'b0, sacc_reg};
        sup_raddr = cnt_reg[EW-1:0];
        cls_we = 1'b0;  cls_waddr = best_reg; cls_wdata = k_next;
        cls_raddr = cnt_reg[EW-1:0];
        unique case (state_reg)
            S_LCHK:
            begin
                adj_we = !adj_row[b_idx] && (loaded_reg != CW'(MAX_EDGES));
                adj_raddr = b_idx;
            end
            S_LWB:
            begin
                adj_we = 1'b1;
                adj_waddr = b_idx;
                adj_wdata = adj_row | (ONE_ROW << a_idx);
                pair_we = 1'b1;
                ends_we = 1'b1;
            end
            S_COPY:
            begin
                adj_raddr = cnt_reg[VW-1:0];
                wrk_we = (cnt_reg != '0);
                if (w_end)
                begin
                    ends_raddr = '0;
                end
            end
            S_SROWV:
            begin
                wrk_raddr = v_reg;
            end
            S_SCNT:
            begin
                sup_we = w_end;
                ends_raddr = EW'(done_reg + 1'b1);
            end
            S_PSEL:
            begin
                cls_we = found_reg;
                ends_raddr = best_reg;
            end
            S_PRU:
            begin
                wrk_raddr = v_reg;
            end
            S_PPA, S_PPB:
            begin
                sup_raddr = pair_rdata;
            end
            S_PSA:
            begin
                sup_we = 1'b1;
                sup_waddr = e_reg;
                sup_wdata = sup_dec(sup_rdata);
                pair_raddr = pair_key(v_reg, cnt_reg[VW-1:0]);
            end
            S_PSB:
            begin
                sup_we = 1'b1;
                sup_waddr = e_reg;
                sup_wdata = sup_dec(sup_rdata);
            end
            S_PCLR:
            begin
                wrk_we = 1'b1;
                wrk_waddr = u_reg;
                wrk_wdata = row_u_reg & ~(ONE_ROW << v_reg);
                sup_we = 1'b1;
                sup_waddr = best_reg;
                sup_wdata = {1'b1, best_s_reg[SW-1:0]};
            end
            S_PCLR2:
            begin
                wrk_we = 1'b1;
                wrk_waddr = v_reg;
                wrk_wdata = row_v_reg & ~(ONE_ROW << u_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            loaded_reg   <= '0;
            cv_reg       <= 1'b0;
            maxc_reg     <= '0;
            rowvalid_reg <= '0;
            bound_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                bound_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg   <= req.mode;
                        va_reg     <= req.vertex_a;
                        vb_reg     <= req.vertex_b;
                        q_reg      <= req.edge_index;
                        status_reg <= ST_OK;
                        cnt_reg    <= '0;
                        rcnt_reg   <= '0;
                        k_reg      <= '0;
                        unique case (req.mode)
                            MODE_CLEAR:
                            begin
                                rowvalid_reg <= '0;
                                loaded_reg   <= '0;
                                cv_reg       <= 1'b0;
                                maxc_reg     <= '0;
                                state_reg    <= S_FSCAN;
                            end
                            MODE_LOAD:
                            begin
                                if (bad_load)
                                begin
                                    status_reg <= ST_BAD;
                                    state_reg  <= S_FSCAN;
                                end
                                else
                                begin
                                    state_reg <= S_LCHK;
                                end
                            end
                            MODE_COMPUTE:
                            begin
                                state_reg <= S_COPY;
                            end
                            MODE_QUERY:
                            begin
                                if (!cv_reg || (XW'(req.edge_index) >= XW'(loaded_reg)))
                                begin
                                    status_reg <= ST_NOCLS;
                                end
                                state_reg <= S_FSCAN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_LCHK:
                begin
                    priority if (adj_row[b_idx])
                    begin
                        status_reg <= ST_BAD;
                        state_reg  <= S_FSCAN;
                    end
                    else if (loaded_reg == CW'(MAX_EDGES))
                    begin
                        status_reg <= ST_FULL;
                        state_reg  <= S_FSCAN;
                    end
                    else
                    begin
                        rowvalid_reg[a_idx] <= 1'b1;
                        state_reg <= S_LWB;
                    end
                end
                S_LWB:
                begin
                    rowvalid_reg[b_idx] <= 1'b1;
                    loaded_reg <= loaded_reg + 1'b1;
                    cv_reg     <= 1'b0;
                    state_reg  <= S_FSCAN;
                end
                S_COPY:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (w_end)
                    begin
                        done_reg <= '0;
                        if (loaded_reg == '0)
                        begin
                            maxc_reg  <= '0;
                            cv_reg    <= 1'b1;
                            cnt_reg   <= '0;
                            state_reg <= S_FSCAN;
                        end
                        else
                        begin
                            state_reg <= S_SROWU;
                        end
                    end
                end
                S_SROWU:
                begin
                    u_reg <= ends_rdata[2*VW-1:VW];
                    v_reg <= ends_rdata[VW-1:0];
                    state_reg <= S_SROWV;
                end
                S_SROWV:
                begin
                    row_u_reg <= wrk_rdata;
                    state_reg <= S_SLATV;
                end
                S_SLATV:
                begin
                    row_v_reg <= wrk_rdata;
                    cnt_reg   <= '0;
                    sacc_reg  <= '0;
                    state_reg <= S_SCNT;
                end
                S_SCNT:
                begin
                    if (w_end)
                    begin
                        cnt_reg <= '0;
                        if (last_edge)
                        begin
                            done_reg   <= '0;
                            best_s_reg <= '1;
                            found_reg  <= 1'b0;
                            state_reg  <= S_PSCAN;
                        end
                        else
                        begin
                            done_reg  <= done_reg + 1'b1;
                            state_reg <= S_SROWU;
                        end
                    end
                    else
                    begin
                        sacc_reg <= sacc_reg + SW'(common_bit);
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                end
                S_PSCAN:
                begin
                    // lowest index wins a tie: strict compare
                    if ((cnt_reg != '0) && !sup_rdata[SW]
                        && ({1'b0, sup_rdata[SW-1:0]} < best_s_reg))
                    begin
                        best_s_reg <= {1'b0, sup_rdata[SW-1:0]};
                        best_reg   <= prev[EW-1:0];
                        found_reg  <= 1'b1;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (scan_end)
                    begin
                        state_reg <= S_PSEL;
                    end
                end
                S_PSEL:
                begin
                    if (found_reg)
                    begin
                        k_reg     <= k_next;
                        state_reg <= S_PENDS;
                    end
                    else
                    begin
                        maxc_reg  <= k_reg;
                        cv_reg    <= 1'b1;
                        cnt_reg   <= '0;
                        state_reg <= S_FSCAN;
                    end
                end
                S_PENDS:
                begin
                    u_reg <= ends_rdata[2*VW-1:VW];
                    v_reg <= ends_rdata[VW-1:0];
                    state_reg <= S_PRU;
                end
                S_PRU:
                begin
                    row_u_reg <= wrk_rdata;
                    state_reg <= S_PRV;
                end
                S_PRV:
                begin
                    row_v_reg <= wrk_rdata;
                    cnt_reg   <= '0;
                    state_reg <= S_PW;
                end
                S_PW:
                begin
                    priority if (w_end)
                    begin
                        state_reg <= S_PCLR;
                    end
                    else if (common_bit)
                    begin
                        state_reg <= S_PPA;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_PPA:
                begin
                    e_reg     <= pair_rdata;
                    state_reg <= S_PSA;
                end
                S_PSA:
                begin
                    state_reg <= S_PPB;
                end
                S_PPB:
                begin
                    e_reg     <= pair_rdata;
                    state_reg <= S_PSB;
                end
                S_PSB:
                begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= S_PW;
                end
                S_PCLR:
                begin
                    state_reg <= S_PCLR2;
                end
                S_PCLR2:
                begin
                    cnt_reg <= '0;
                    if (last_edge)
                    begin
                        maxc_reg  <= k_reg;
                        cv_reg    <= 1'b1;
                        state_reg <= S_FSCAN;
                    end
                    else
                    begin
                        done_reg   <= done_reg + 1'b1;
                        best_s_reg <= '1;
                        found_reg  <= 1'b0;
                        state_reg  <= S_PSCAN;
                    end
                end
                S_FSCAN:
                begin
                    if (!cv_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (cnt_reg != '0)
                        begin
                            if (is_removable(8'(cls_rdata), bound_reg))
                            begin
                                rcnt_reg <= rcnt_reg + 1'b1;
                            end
                            if (XW'(prev) == XW'(q_reg))
                            begin
                                qcls_reg <= cls_rdata;
                            end
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                        if (scan_end)
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cls_w = 8'(qcls_reg);
    assign ub_w  = (loaded_reg == '0) ? 9'd1 : 9'(maxc_reg) + 9'd2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_class_reg  <= '0;
            out_rem_reg    <= 1'b0;
            if ((mode_reg == MODE_QUERY) && (status_reg == ST_OK))
            begin
                out_class_reg <= (cls_w > 8'd63) ? 6'd63 : cls_w[5:0];
                out_rem_reg   <= is_removable(cls_w, bound_reg);
            end
            out_cub_reg  <= cv_reg ? ((ub_w > 9'd127) ? 7'd127 : ub_w[6:0]) : '0;
            out_rcnt_reg <= cv_reg ? COUNT_W'(rcnt_reg) : '0;
            out_ecnt_reg <= COUNT_W'(loaded_reg);
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = out_status_reg;
    assign rsp.edge_class         = out_class_reg;
    assign rsp.removable          = out_rem_reg;
    assign rsp.clique_upper_bound = out_cub_reg;
    assign rsp.removable_count    = out_rcnt_reg;
    assign rsp.loaded_count       = out_ecnt_reg;

endmodule

// ===== design/tdec_checker.sv =====
// Port-level checks for the truss decomposition block, bound to the top level.
`timescale 1ns / 1ps

module tdec_checker
    import tdec_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input status_t            rsp_status,
    input logic [CLASS_W-1:0] rsp_edge_class,
    input logic               rsp_removable,
    input logic [BOUND_W-1:0] rsp_cub,
    input logic [COUNT_W-1:0] rsp_rcnt
);

    // hold a response until it is taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> (rsp_edge_class == '0) && !rsp_removable)
        else $error("failed request carries query data");

    a_no_class_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_cub == '0) |-> (rsp_rcnt == '0))
        else $error("removable count without valid classes");

    a_rem_needs_classes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_removable |-> (rsp_cub != '0) && (rsp_status == ST_OK))
        else $error("removable edge reported without classes");

endmodule

bind truss_decomposition tdec_checker u_tdec_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_edge_class (rsp.edge_class),
    .rsp_removable  (rsp.removable),
    .rsp_cub        (rsp.clique_upper_bound),
    .rsp_rcnt       (rsp.removable_count)
);
